// File: design/rtpa_pkg.sv
// ============================================================================
// rtpa_pkg: shared types and constants of the RTP audio packetizer
// Configuration register indexes, header constants and the structures
// that travel between the front end, the queue and the back end.
// ============================================================================
package rtpa_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MTU              = 3'd0;
    localparam logic [2:0] CFG_PAYLOAD_FORMAT   = 3'd1;
    localparam logic [2:0] CFG_PAYLOAD_TYPE     = 3'd2;
    localparam logic [2:0] CFG_SSRC             = 3'd3;
    localparam logic [2:0] CFG_INITIAL_SEQUENCE = 3'd4;

    // Payload formats.
    localparam logic FMT_MPEG = 1'b0;
    localparam logic FMT_AC3  = 1'b1;

    // Register reset values.
    localparam logic [15:0] MTU_DEFAULT          = 16'd1500;
    localparam logic [6:0]  PAYLOAD_TYPE_DEFAULT = 7'd14;

    // An mtu at or below this value falls back to the default.
    localparam logic [15:0] MTU_MIN_INVALID = 16'd16;

    // Header constants.
    localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
    localparam logic [15:0] HDR_BYTES_MPEG   = 16'd16;
    localparam logic [15:0] HDR_BYTES_AC3    = 16'd14;
    localparam logic [4:0]  HDR_LEN_MPEG     = 5'd16;
    localparam logic [4:0]  HDR_LEN_AC3      = 5'd14;
    localparam logic [7:0]  AC3_UNIT_COUNT   = 8'd1;

    // Item queue between the front end and the back end.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Timestamp divider: 9*pts is at most 67 bits, padded to 68 and
    // consumed four bits per cycle.
    localparam int         DIV_BITS       = 68;
    localparam int         DIV_RADIX_BITS = 4;
    localparam logic [4:0] DIV_LAST_STEP  = 5'(DIV_BITS / DIV_RADIX_BITS - 1);
    localparam logic [7:0] TS_DIVISOR     = 8'd100;

    typedef struct packed {
        logic [15:0] mtu;
        logic        payload_format;
        logic [6:0]  payload_type;
        logic [31:0] ssrc;
        logic        seq_load;
        logic [15:0] seq_value;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic        marker;
        logic        fmt;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [15:0] offset;
        logic        eop;
        logic        eof;
    } q_entry_t;

endpackage

// File: design/rtpa_tsdiv.sv
// ============================================================================
// rtpa_tsdiv: RTP timestamp unit
// Computes floor(pts * 9 / 100) modulo 2^32 by radix-16 long division.
// ============================================================================
module rtpa_tsdiv
    import rtpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [62:0] pts,
    output logic        busy,
    output logic        done,
    output logic [31:0] ts
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [DIV_BITS-1:0] x_reg, x_next;
    logic [6:0]          r_reg, r_next;
    logic [31:0]         q_reg, q_next;

    // Four restoring division steps per cycle on a remainder below 100.
    always_comb
    begin
        logic [7:0] t;
        logic [6:0] r;
        logic [3:0] qb;
        r  = r_reg;
        qb = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            t = {r, x_reg[DIV_BITS-1-i]};
            if (t >= TS_DIVISOR)
            begin
                t      = t - TS_DIVISOR;
                qb[3-i] = 1'b1;
            end
            r = t[6:0];
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = DIV_BITS'({pts, 3'b000}) + DIV_BITS'(pts);
            r_next    = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            x_next   = {x_reg[DIV_BITS-1-DIV_RADIX_BITS:0], {DIV_RADIX_BITS{1'b0}}};
            r_next   = r;
            q_next   = {q_reg[27:0], qb};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == DIV_LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        r_reg <= r_next;
        q_reg <= q_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign ts   = q_reg;

endmodule

// File: design/rtpa_front.sv
// ============================================================================
// rtpa_front: packetizer front end
// Accepts frame bytes, tracks frame and fragment boundaries and pushes one
// classified item per byte into the queue.
// ============================================================================
module rtpa_front
    import rtpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [15:0] frame_size,
    input  logic [62:0] pts,
    input  logic        q_full,
    output logic        q_push,
    output q_entry_t    q_din
);

    logic [15:0] fbl_reg, fbl_next;
    logic [15:0] pbl_reg, pbl_next;
    logic [15:0] off_reg, off_next;
    logic [31:0] ts_reg, ts_next;
    logic [15:0] seq_reg, seq_next;
    logic        ts_valid_reg, ts_valid_next;

    logic        div_start, div_busy, div_done;
    logic [31:0] div_ts;

    logic        new_frame, new_pkt, accept, last;
    logic [15:0] fs, fbl_eff, pbl_eff, off_eff, mtu_eff, max_len, len;
    logic [15:0] pbl_after, fbl_after;
    logic [31:0] ts_eff;

    rtpa_tsdiv u_tsdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .pts   (pts),
        .busy  (div_busy),
        .done  (div_done),
        .ts    (div_ts)
    );

    always_comb
    begin
        new_frame = (fbl_reg == 16'd0);
        fs        = (frame_size == 16'd0) ? 16'd1 : frame_size;
        fbl_eff   = new_frame ? fs : fbl_reg;
        pbl_eff   = new_frame ? 16'd0 : pbl_reg;
        off_eff   = new_frame ? 16'd0 : off_reg;
        ts_eff    = new_frame ? div_ts : ts_reg;
        new_pkt   = (pbl_eff == 16'd0);
        mtu_eff   = (cfg.mtu <= MTU_MIN_INVALID) ? MTU_DEFAULT : cfg.mtu;
        max_len   = mtu_eff - ((cfg.payload_format == FMT_AC3) ? HDR_BYTES_AC3
                                                                : HDR_BYTES_MPEG);
        len       = (fbl_eff < max_len) ? fbl_eff : max_len;
        last      = (fbl_eff <= max_len);
        pbl_after = (new_pkt ? len : pbl_eff) - 16'd1;
        fbl_after = fbl_eff - 16'd1;

        // The first byte of a frame waits for its timestamp. The unit is not
        // started again in the cycle that it reports its result.
        in_stall  = q_full || (new_frame && !ts_valid_reg);
        accept    = in_valid && !in_stall;
        div_start = in_valid && new_frame && !ts_valid_reg && !div_busy && !div_done;

        q_push        = accept;
        q_din.data    = data_byte;
        q_din.hdr     = new_pkt;
        q_din.marker  = last;
        q_din.fmt     = cfg.payload_format;
        q_din.seq     = seq_reg;
        q_din.ts      = ts_eff;
        q_din.offset  = off_eff;
        q_din.eop     = (pbl_after == 16'd0);
        q_din.eof     = (fbl_after == 16'd0);

        fbl_next      = fbl_reg;
        pbl_next      = pbl_reg;
        off_next      = off_reg;
        ts_next       = ts_reg;
        seq_next      = seq_reg;
        ts_valid_next = ts_valid_reg;
        if (div_done)
        begin
            ts_valid_next = 1'b1;
        end
        if (accept)
        begin
            fbl_next = fbl_after;
            pbl_next = pbl_after;
            off_next = new_pkt ? off_eff + len : off_eff;
            ts_next  = ts_eff;
            if (new_frame)
            begin
                ts_valid_next = 1'b0;
            end
            if (new_pkt)
            begin
                seq_next = seq_reg + 16'd1;
            end
        end
        if (cfg.seq_load)
        begin
            seq_next = cfg.seq_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbl_reg      <= '0;
            pbl_reg      <= '0;
            off_reg      <= '0;
            ts_reg       <= '0;
            seq_reg      <= '0;
            ts_valid_reg <= 1'b0;
        end
        else
        begin
            fbl_reg      <= fbl_next;
            pbl_reg      <= pbl_next;
            off_reg      <= off_next;
            ts_reg       <= ts_next;
            seq_reg      <= seq_next;
            ts_valid_reg <= ts_valid_next;
        end
    end

endmodule

// File: design/rtpa_queue.sv
// ============================================================================
// rtpa_queue: item queue
// Short first-in first-out buffer between the front end and the back end.
// ============================================================================
module rtpa_queue
    import rtpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t din,
    input  logic     pop,
    output q_entry_t dout,
    output logic     full,
    output logic     empty
);

    q_entry_t          mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign full  = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule

// File: design/rtpa_back.sv
// ============================================================================
// rtpa_back: packetizer back end
// Expands queued items into RTP header bytes and payload bytes, one byte
// per cycle unless the output stalls, through a registered output stage.
// ============================================================================
module rtpa_back
    import rtpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  q_entry_t   head,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       end_of_packet,
    output logic       end_of_frame
);

    logic [4:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       eop_reg, eop_next;
    logic       eof_reg, eof_next;

    logic       adv, in_hdr;
    logic [4:0] hdr_len;
    logic [7:0] hdr_byte;

    always_comb
    begin
        hdr_len = (head.fmt == FMT_AC3) ? HDR_LEN_AC3 : HDR_LEN_MPEG;
        in_hdr  = head.hdr && (idx_reg < hdr_len);
        adv     = !out_valid_reg || !out_stall;

        case (idx_reg)
            5'd0:    hdr_byte = RTP_VERSION_BYTE;
            5'd1:    hdr_byte = {head.marker, cfg.payload_type};
            5'd2:    hdr_byte = head.seq[15:8];
            5'd3:    hdr_byte = head.seq[7:0];
            5'd4:    hdr_byte = head.ts[31:24];
            5'd5:    hdr_byte = head.ts[23:16];
            5'd6:    hdr_byte = head.ts[15:8];
            5'd7:    hdr_byte = head.ts[7:0];
            5'd8:    hdr_byte = cfg.ssrc[31:24];
            5'd9:    hdr_byte = cfg.ssrc[23:16];
            5'd10:   hdr_byte = cfg.ssrc[15:8];
            5'd11:   hdr_byte = cfg.ssrc[7:0];
            5'd12:   hdr_byte = (head.fmt == FMT_AC3) ? AC3_UNIT_COUNT : 8'd0;
            5'd14:   hdr_byte = head.offset[15:8];
            5'd15:   hdr_byte = head.offset[7:0];
            default: hdr_byte = 8'd0;
        endcase

        q_pop          = 1'b0;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        eop_next       = eop_reg;
        eof_next       = eof_reg;
        if (adv)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                if (in_hdr)
                begin
                    byte_next = hdr_byte;
                    eop_next  = 1'b0;
                    eof_next  = 1'b0;
                    idx_next  = idx_reg + 5'd1;
                end
                else
                begin
                    byte_next = head.data;
                    eop_next  = head.eop;
                    eof_next  = head.eof;
                    idx_next  = '0;
                    q_pop     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eop_reg  <= eop_next;
        eof_reg  <= eof_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = byte_reg;
    assign end_of_packet = eop_reg;
    assign end_of_frame  = eof_reg;

    a_eof_is_eop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> end_of_packet)
        else $error("end of frame without end of packet");

    a_hdr_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !q_empty && in_hdr) |=> (!end_of_packet && !end_of_frame))
        else $error("flag set on a header byte");

    a_pop_resets_idx: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == 5'd0))
        else $error("header index not cleared after a payload byte");

endmodule

// File: design/rtp_audio_packetizer_core.sv
// ============================================================================
// rtp_audio_packetizer_core: RTP packetizer for MPEG audio and AC3 frames
// Turns a byte stream of audio frames into a byte stream of RTP packets.
// ============================================================================
// Audio frame bytes enter on the input channel, and payload bytes pass, at
// one per cycle unless stalled; the first byte of each frame also carries the
// frame size and the presentation time in microseconds. Each packet start
// adds 16 header bytes (MPEG audio) or 14 (AC3) on the output, emitted by the
// back end from a 4-entry queue while the front end keeps accepting items
// until the queue fills. The first byte of every frame is held while the
// timestamp unit works out pts*9/100 four quotient bits per cycle; this
// overlaps with the back end draining the previous frame. Configuration
// registers are written through the plain write port (index 0 mtu, 1 payload
// format, 2 payload type, 3 ssrc, 4 initial sequence, which loads the
// sequence counter at once) and must only change while the block is idle.
// An mtu of 16 or less is treated as 1500, and a frame size of zero as one.
module rtp_audio_packetizer_core
    import rtpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [15:0] frame_size,
    input  logic [62:0] pts,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        end_of_packet,
    output logic        end_of_frame
);

    // Configuration registers.
    logic [15:0] mtu_reg;
    logic        payload_format_reg;
    logic [6:0]  payload_type_reg;
    logic [31:0] ssrc_reg;

    cfg_t     cfg;
    logic     q_full, q_empty, q_push, q_pop;
    q_entry_t q_din, q_dout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg            <= MTU_DEFAULT;
            payload_format_reg <= FMT_MPEG;
            payload_type_reg   <= PAYLOAD_TYPE_DEFAULT;
            ssrc_reg           <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MTU:            mtu_reg            <= cfg_data[15:0];
                CFG_PAYLOAD_FORMAT: payload_format_reg <= cfg_data[0];
                CFG_PAYLOAD_TYPE:   payload_type_reg   <= cfg_data[6:0];
                CFG_SSRC:           ssrc_reg           <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The initial sequence is not stored here; a write loads the front
    // end's sequence counter directly.
    always_comb
    begin
        cfg.mtu            = mtu_reg;
        cfg.payload_format = payload_format_reg;
        cfg.payload_type   = payload_type_reg;
        cfg.ssrc           = ssrc_reg;
        cfg.seq_load       = cfg_write && (cfg_index == CFG_INITIAL_SEQUENCE);
        cfg.seq_value      = cfg_data[15:0];
    end

    rtpa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .frame_size (frame_size),
        .pts        (pts),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_din      (q_din)
    );

    rtpa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    rtpa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head          (q_dout),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .end_of_packet (end_of_packet),
        .end_of_frame  (end_of_frame)
    );

endmodule
